[hw/rtl/rvic_pkg.sv]
`default_nettype none

package rvic_pkg;

	localparam int ClassWidth = 7;

	typedef logic [ClassWidth-1:0] class_t;
	typedef logic [6:0]            opcode_t;
	typedef logic [2:0]            funct3_t;
	typedef logic [6:0]            funct7_t;
	typedef logic [5:0]            funct6_t;

	typedef struct packed {
		class_t instr_class;
		logic   unknown_opcode;
	} rvic_result_t;

	localparam opcode_t OP_LUI      = 7'b0110111;
	localparam opcode_t OP_AUIPC    = 7'b0010111;
	localparam opcode_t OP_JAL      = 7'b1101111;
	localparam opcode_t OP_JALR     = 7'b1100111;
	localparam opcode_t OP_BRANCH   = 7'b1100011;
	localparam opcode_t OP_LOAD     = 7'b0000011;
	localparam opcode_t OP_STORE    = 7'b0100011;
	localparam opcode_t OP_IMM      = 7'b0010011;
	localparam opcode_t OP_REG      = 7'b0110011;
	localparam opcode_t OP_MISC_MEM = 7'b0001111;
	localparam opcode_t OP_SYSTEM   = 7'b1110011;
	localparam opcode_t OP_IMM_32   = 7'b0011011;
	localparam opcode_t OP_REG_32   = 7'b0111011;

	localparam funct7_t F7_BASE = 7'b0000000;
	localparam funct7_t F7_MULDIV = 7'b0000001;
	localparam funct7_t F7_ALT = 7'b0100000;
	localparam funct6_t F6_BASE = 6'b000000;
	localparam funct6_t F6_ALT = 6'b010000;

	localparam logic [31:0] WORD_ECALL  = 32'h00000073;
	localparam logic [31:0] WORD_EBREAK = 32'h00100073;

	localparam class_t CLS_LUI     = 7'd0;
	localparam class_t CLS_AUIPC   = 7'd1;
	localparam class_t CLS_JAL     = 7'd2;
	localparam class_t CLS_JALR    = 7'd3;
	localparam class_t CLS_BEQ     = 7'd4;
	localparam class_t CLS_BNE     = 7'd5;
	localparam class_t CLS_BLT     = 7'd6;
	localparam class_t CLS_BGE     = 7'd7;
	localparam class_t CLS_BLTU    = 7'd8;
	localparam class_t CLS_BGEU    = 7'd9;
	localparam class_t CLS_LB      = 7'd10;
	localparam class_t CLS_LH      = 7'd11;
	localparam class_t CLS_LW      = 7'd12;
	localparam class_t CLS_LBU     = 7'd13;
	localparam class_t CLS_LHU     = 7'd14;
	localparam class_t CLS_LWU     = 7'd15;
	localparam class_t CLS_LD      = 7'd16;
	localparam class_t CLS_SB      = 7'd17;
	localparam class_t CLS_SH      = 7'd18;
	localparam class_t CLS_SW      = 7'd19;
	localparam class_t CLS_SD      = 7'd20;
	localparam class_t CLS_ADDI    = 7'd21;
	localparam class_t CLS_SLTI    = 7'd22;
	localparam class_t CLS_SLTIU   = 7'd23;
	localparam class_t CLS_XORI    = 7'd24;
	localparam class_t CLS_ORI     = 7'd25;
	localparam class_t CLS_ANDI    = 7'd26;
	localparam class_t CLS_SLLI    = 7'd27;
	localparam class_t CLS_SRLI    = 7'd28;
	localparam class_t CLS_SRAI    = 7'd29;
	localparam class_t CLS_ADD     = 7'd30;
	localparam class_t CLS_SUB     = 7'd31;
	localparam class_t CLS_SLL     = 7'd32;
	localparam class_t CLS_SLT     = 7'd33;
	localparam class_t CLS_SLTU    = 7'd34;
	localparam class_t CLS_XOR     = 7'd35;
	localparam class_t CLS_SRL     = 7'd36;
	localparam class_t CLS_SRA     = 7'd37;
	localparam class_t CLS_OR      = 7'd38;
	localparam class_t CLS_AND     = 7'd39;
	localparam class_t CLS_MUL     = 7'd40;
	localparam class_t CLS_MULH    = 7'd41;
	localparam class_t CLS_MULHSU  = 7'd42;
	localparam class_t CLS_MULHU   = 7'd43;
	localparam class_t CLS_DIV     = 7'd44;
	localparam class_t CLS_DIVU    = 7'd45;
	localparam class_t CLS_REM     = 7'd46;
	localparam class_t CLS_REMU    = 7'd47;
	localparam class_t CLS_FENCE   = 7'd48;
	localparam class_t CLS_FENCE_I = 7'd49;
	localparam class_t CLS_ECALL   = 7'd50;
	localparam class_t CLS_EBREAK  = 7'd51;
	localparam class_t CLS_CSRRW   = 7'd52;
	localparam class_t CLS_CSRRS   = 7'd53;
	localparam class_t CLS_CSRRC   = 7'd54;
	localparam class_t CLS_CSRRWI  = 7'd55;
	localparam class_t CLS_CSRRSI  = 7'd56;
	localparam class_t CLS_CSRRCI  = 7'd57;
	localparam class_t CLS_ADDIW   = 7'd58;
	localparam class_t CLS_SLLIW   = 7'd59;
	localparam class_t CLS_SRLIW   = 7'd60;
	localparam class_t CLS_SRAIW   = 7'd61;
	localparam class_t CLS_ADDW    = 7'd62;
	localparam class_t CLS_SUBW    = 7'd63;
	localparam class_t CLS_SLLW    = 7'd64;
	localparam class_t CLS_SRLW    = 7'd65;
	localparam class_t CLS_SRAW    = 7'd66;
	localparam class_t CLS_MULW    = 7'd67;
	localparam class_t CLS_DIVW    = 7'd68;
	localparam class_t CLS_DIVUW   = 7'd69;
	localparam class_t CLS_REMW    = 7'd70;
	localparam class_t CLS_REMUW   = 7'd71;
	localparam class_t CLS_NONE    = 7'd72;

endpackage

`default_nettype wire

[hw/rtl/rvic_decode.sv]
`default_nettype none

module rvic_decode
	import rvic_pkg::*;
(
	input  wire logic [31:0] instruction,
	output rvic_result_t     result
);

	opcode_t op;
	funct3_t f3;
	funct7_t f7;
	funct6_t f6;

	assign op = instruction[6:0];
	assign f3 = instruction[14:12];
	assign f7 = instruction[31:25];
	assign f6 = instruction[31:26];

	always_comb begin
		result.instr_class    = CLS_NONE;
		result.unknown_opcode = 1'b0;
		unique case (op)
			OP_LUI:   result.instr_class = CLS_LUI;
			OP_AUIPC: result.instr_class = CLS_AUIPC;
			OP_JAL:   result.instr_class = CLS_JAL;
			OP_JALR: begin
				if (f3 == 3'd0) result.instr_class = CLS_JALR;
			end
			OP_BRANCH: begin
				unique case (f3)
					3'd0:    result.instr_class = CLS_BEQ;
					3'd1:    result.instr_class = CLS_BNE;
					3'd4:    result.instr_class = CLS_BLT;
					3'd5:    result.instr_class = CLS_BGE;
					3'd6:    result.instr_class = CLS_BLTU;
					3'd7:    result.instr_class = CLS_BGEU;
					default: result.instr_class = CLS_NONE;
				endcase
			end
			OP_LOAD: begin
				unique case (f3)
					3'd0:    result.instr_class = CLS_LB;
					3'd1:    result.instr_class = CLS_LH;
					3'd2:    result.instr_class = CLS_LW;
					3'd3:    result.instr_class = CLS_LD;
					3'd4:    result.instr_class = CLS_LBU;
					3'd5:    result.instr_class = CLS_LHU;
					3'd6:    result.instr_class = CLS_LWU;
					default: result.instr_class = CLS_NONE;
				endcase
			end
			OP_STORE: begin
				unique case (f3)
					3'd0:    result.instr_class = CLS_SB;
					3'd1:    result.instr_class = CLS_SH;
					3'd2:    result.instr_class = CLS_SW;
					3'd3:    result.instr_class = CLS_SD;
					default: result.instr_class = CLS_NONE;
				endcase
			end
			OP_IMM: begin
				unique case (f3)
					3'd0: result.instr_class = CLS_ADDI;
					3'd1: begin
						if (f6 == F6_BASE) result.instr_class = CLS_SLLI;
					end
					3'd2: result.instr_class = CLS_SLTI;
					3'd3: result.instr_class = CLS_SLTIU;
					3'd4: result.instr_class = CLS_XORI;
					3'd5: begin
						if (f6 == F6_BASE) result.instr_class = CLS_SRLI;
						else if (f6 == F6_ALT) result.instr_class = CLS_SRAI;
					end
					3'd6: result.instr_class = CLS_ORI;
					3'd7: result.instr_class = CLS_ANDI;
					default: result.instr_class = CLS_NONE;
				endcase
			end
			OP_REG: begin
				if (f7 == F7_BASE) begin
					unique case (f3)
						3'd0: result.instr_class = CLS_ADD;
						3'd1: result.instr_class = CLS_SLL;
						3'd2: result.instr_class = CLS_SLT;
						3'd3: result.instr_class = CLS_SLTU;
						3'd4: result.instr_class = CLS_XOR;
						3'd5: result.instr_class = CLS_SRL;
						3'd6: result.instr_class = CLS_OR;
						3'd7: result.instr_class = CLS_AND;
						default: result.instr_class = CLS_NONE;
					endcase
				end else if (f7 == F7_MULDIV) begin
					unique case (f3)
						3'd0: result.instr_class = CLS_MUL;
						3'd1: result.instr_class = CLS_MULH;
						3'd2: result.instr_class = CLS_MULHSU;
						3'd3: result.instr_class = CLS_MULHU;
						3'd4: result.instr_class = CLS_DIV;
						3'd5: result.instr_class = CLS_DIVU;
						3'd6: result.instr_class = CLS_REM;
						3'd7: result.instr_class = CLS_REMU;
						default: result.instr_class = CLS_NONE;
					endcase
				end else if (f7 == F7_ALT) begin
					if (f3 == 3'd0) result.instr_class = CLS_SUB;
					else if (f3 == 3'd5) result.instr_class = CLS_SRA;
				end
			end
			OP_MISC_MEM: begin
				if (f3 == 3'd0) result.instr_class = CLS_FENCE;
				else if (f3 == 3'd1) result.instr_class = CLS_FENCE_I;
			end
			OP_SYSTEM: begin
				if (instruction == WORD_ECALL) begin
					result.instr_class = CLS_ECALL;
				end else if (instruction == WORD_EBREAK) begin
					result.instr_class = CLS_EBREAK;
				end else begin
					unique case (f3)
						3'd1:    result.instr_class = CLS_CSRRW;
						3'd2:    result.instr_class = CLS_CSRRS;
						3'd3:    result.instr_class = CLS_CSRRC;
						3'd5:    result.instr_class = CLS_CSRRWI;
						3'd6:    result.instr_class = CLS_CSRRSI;
						3'd7:    result.instr_class = CLS_CSRRCI;
						default: result.instr_class = CLS_NONE;
					endcase
				end
			end
			OP_IMM_32: begin
				if (f3 == 3'd0) result.instr_class = CLS_ADDIW;
				else if (f3 == 3'd1 && f7 == F7_BASE) result.instr_class = CLS_SLLIW;
				else if (f3 == 3'd5 && f7 == F7_BASE) result.instr_class = CLS_SRLIW;
				else if (f3 == 3'd5 && f7 == F7_ALT) result.instr_class = CLS_SRAIW;
			end
			OP_REG_32: begin
				if (f7 == F7_BASE) begin
					if (f3 == 3'd0) result.instr_class = CLS_ADDW;
					else if (f3 == 3'd1) result.instr_class = CLS_SLLW;
					else if (f3 == 3'd5) result.instr_class = CLS_SRLW;
				end else if (f7 == F7_ALT) begin
					if (f3 == 3'd0) result.instr_class = CLS_SUBW;
					else if (f3 == 3'd5) result.instr_class = CLS_SRAW;
				end else if (f7 == F7_MULDIV) begin
					unique case (f3)
						3'd0:    result.instr_class = CLS_MULW;
						3'd4:    result.instr_class = CLS_DIVW;
						3'd5:    result.instr_class = CLS_DIVUW;
						3'd6:    result.instr_class = CLS_REMW;
						3'd7:    result.instr_class = CLS_REMUW;
						default: result.instr_class = CLS_NONE;
					endcase
				end
			end
			default: begin
				result.instr_class    = CLS_NONE;
				result.unknown_opcode = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

[hw/rtl/rv64im_instruction_classifier.sv]
// RV64IM instruction classifier.
// The input channel (in_valid, in_stall, instruction) takes one 32-bit
// instruction word per transaction. The output channel (out_valid, out_stall,
// instr_class, unknown_opcode) returns exactly one result per input
// transaction, in order. instr_class numbers the instruction classes from
// LUI as 0 up to REMUW as 71, and 72 marks an encoding that matches no
// instruction. unknown_opcode is set when the major opcode is not one of
// the thirteen that the block decodes.
// The word is captured in an input register and decoded into the output
// register, from which the result is offered. Throughput is one transaction
// per cycle while out_stall is low, set by the single decode stage.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more word; in_stall rises only when both
// registers are full. Reset empties both stages and needs no further setup.
`default_nettype none

module rv64im_instruction_classifier
	import rvic_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [31:0]      instruction,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [ClassWidth-1:0] instr_class,
	output logic                  unknown_opcode
);

	logic         valid_s1;
	logic [31:0]  instruction_s1;
	logic         valid_s2;
	rvic_result_t result_s2;
	rvic_result_t decoded;
	logic         advance_s2;
	logic         accept_in;

	assign advance_s2 = !valid_s2 || !out_stall;
	assign in_stall   = valid_s1 && !advance_s2;
	assign accept_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			instruction_s1 <= instruction;
		end
	end

	rvic_decode u_decode (
		.instruction (instruction_s1),
		.result      (decoded)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s2 && valid_s1) begin
			result_s2 <= decoded;
		end
	end

	assign out_valid      = valid_s2;
	assign instr_class    = result_s2.instr_class;
	assign unknown_opcode = result_s2.unknown_opcode;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("Input stalled while a stage was free.");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept_in |=> valid_s1)
		else $error("Accepted transaction did not reach the input register.");

	a_class_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (instr_class <= CLS_NONE))
		else $error("Class id out of range.");

	a_unknown_gives_none: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && unknown_opcode) |-> (instr_class == CLS_NONE))
		else $error("Unknown opcode with a valid class.");

endmodule

`default_nettype wire

[verif/testbench.sv]
`default_nettype none

module testbench;
	import rvic_pkg::*;

	localparam int RandomWords = 1050;
	localparam int IdleLimit = 2000;
	localparam int HoldStart = 600;
	localparam int HoldCycles = 80;
	localparam int NumClasses = 73;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [31:0]      instruction = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [ClassWidth-1:0] instr_class;
	logic             unknown_opcode;

	logic [31:0]  pending_words[$];
	rvic_result_t expected_results[$];

	int unsigned mismatch_count = 0;
	int unsigned checked_count = 0;
	int unsigned input_stall_cycles = 0;
	int unsigned idle_cycles = 0;
	bit          class_seen[NumClasses];

	rv64im_instruction_classifier DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.instruction(instruction),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.instr_class(instr_class),
		.unknown_opcode(unknown_opcode)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic rvic_result_t predict_class(input logic [31:0] w);
		rvic_result_t r;
		opcode_t op;
		funct3_t f3;
		funct7_t f7;
		funct6_t f6;
		op = w[6:0];
		f3 = w[14:12];
		f7 = w[31:25];
		f6 = w[31:26];
		r.instr_class = CLS_NONE;
		r.unknown_opcode = 1'b0;
		case (op)
			OP_LUI: r.instr_class = CLS_LUI;
			OP_AUIPC: r.instr_class = CLS_AUIPC;
			OP_JAL: r.instr_class = CLS_JAL;
			OP_JALR: if (f3 == 3'd0) r.instr_class = CLS_JALR;
			OP_BRANCH: begin
				case (f3)
					3'd0: r.instr_class = CLS_BEQ;
					3'd1: r.instr_class = CLS_BNE;
					3'd4: r.instr_class = CLS_BLT;
					3'd5: r.instr_class = CLS_BGE;
					3'd6: r.instr_class = CLS_BLTU;
					3'd7: r.instr_class = CLS_BGEU;
					default: r.instr_class = CLS_NONE;
				endcase
			end
			OP_LOAD: begin
				case (f3)
					3'd0: r.instr_class = CLS_LB;
					3'd1: r.instr_class = CLS_LH;
					3'd2: r.instr_class = CLS_LW;
					3'd3: r.instr_class = CLS_LD;
					3'd4: r.instr_class = CLS_LBU;
					3'd5: r.instr_class = CLS_LHU;
					3'd6: r.instr_class = CLS_LWU;
					default: r.instr_class = CLS_NONE;
				endcase
			end
			OP_STORE: begin
				case (f3)
					3'd0: r.instr_class = CLS_SB;
					3'd1: r.instr_class = CLS_SH;
					3'd2: r.instr_class = CLS_SW;
					3'd3: r.instr_class = CLS_SD;
					default: r.instr_class = CLS_NONE;
				endcase
			end
			OP_IMM: begin
				case (f3)
					3'd0: r.instr_class = CLS_ADDI;
					3'd1: if (f6 == F6_BASE) r.instr_class = CLS_SLLI;
					3'd2: r.instr_class = CLS_SLTI;
					3'd3: r.instr_class = CLS_SLTIU;
					3'd4: r.instr_class = CLS_XORI;
					3'd5: begin
						if (f6 == F6_BASE) r.instr_class = CLS_SRLI;
						else if (f6 == F6_ALT) r.instr_class = CLS_SRAI;
					end
					3'd6: r.instr_class = CLS_ORI;
					default: r.instr_class = CLS_ANDI;
				endcase
			end
			OP_REG: begin
				if (f7 == F7_BASE) begin
					case (f3)
						3'd0: r.instr_class = CLS_ADD;
						3'd1: r.instr_class = CLS_SLL;
						3'd2: r.instr_class = CLS_SLT;
						3'd3: r.instr_class = CLS_SLTU;
						3'd4: r.instr_class = CLS_XOR;
						3'd5: r.instr_class = CLS_SRL;
						3'd6: r.instr_class = CLS_OR;
						default: r.instr_class = CLS_AND;
					endcase
				end else if (f7 == F7_MULDIV) begin
					case (f3)
						3'd0: r.instr_class = CLS_MUL;
						3'd1: r.instr_class = CLS_MULH;
						3'd2: r.instr_class = CLS_MULHSU;
						3'd3: r.instr_class = CLS_MULHU;
						3'd4: r.instr_class = CLS_DIV;
						3'd5: r.instr_class = CLS_DIVU;
						3'd6: r.instr_class = CLS_REM;
						default: r.instr_class = CLS_REMU;
					endcase
				end else if (f7 == F7_ALT) begin
					if (f3 == 3'd0) r.instr_class = CLS_SUB;
					else if (f3 == 3'd5) r.instr_class = CLS_SRA;
				end
			end
			OP_MISC_MEM: begin
				if (f3 == 3'd0) r.instr_class = CLS_FENCE;
				else if (f3 == 3'd1) r.instr_class = CLS_FENCE_I;
			end
			OP_SYSTEM: begin
				if (w == WORD_ECALL) r.instr_class = CLS_ECALL;
				else if (w == WORD_EBREAK) r.instr_class = CLS_EBREAK;
				else begin
					case (f3)
						3'd1: r.instr_class = CLS_CSRRW;
						3'd2: r.instr_class = CLS_CSRRS;
						3'd3: r.instr_class = CLS_CSRRC;
						3'd5: r.instr_class = CLS_CSRRWI;
						3'd6: r.instr_class = CLS_CSRRSI;
						3'd7: r.instr_class = CLS_CSRRCI;
						default: r.instr_class = CLS_NONE;
					endcase
				end
			end
			OP_IMM_32: begin
				if (f3 == 3'd0) r.instr_class = CLS_ADDIW;
				else if (f3 == 3'd1 && f7 == F7_BASE) r.instr_class = CLS_SLLIW;
				else if (f3 == 3'd5 && f7 == F7_BASE) r.instr_class = CLS_SRLIW;
				else if (f3 == 3'd5 && f7 == F7_ALT) r.instr_class = CLS_SRAIW;
			end
			OP_REG_32: begin
				if (f7 == F7_BASE) begin
					if (f3 == 3'd0) r.instr_class = CLS_ADDW;
					else if (f3 == 3'd1) r.instr_class = CLS_SLLW;
					else if (f3 == 3'd5) r.instr_class = CLS_SRLW;
				end else if (f7 == F7_ALT) begin
					if (f3 == 3'd0) r.instr_class = CLS_SUBW;
					else if (f3 == 3'd5) r.instr_class = CLS_SRAW;
				end else if (f7 == F7_MULDIV) begin
					case (f3)
						3'd0: r.instr_class = CLS_MULW;
						3'd4: r.instr_class = CLS_DIVW;
						3'd5: r.instr_class = CLS_DIVUW;
						3'd6: r.instr_class = CLS_REMW;
						3'd7: r.instr_class = CLS_REMUW;
						default: r.instr_class = CLS_NONE;
					endcase
				end
			end
			default: r.unknown_opcode = 1'b1;
		endcase
		return r;
	endfunction

	function automatic opcode_t known_opcode(input int unsigned idx);
		case (idx)
			0: return OP_LUI;
			1: return OP_AUIPC;
			2: return OP_JAL;
			3: return OP_JALR;
			4: return OP_BRANCH;
			5: return OP_LOAD;
			6: return OP_STORE;
			7: return OP_IMM;
			8: return OP_REG;
			9: return OP_MISC_MEM;
			10: return OP_SYSTEM;
			11: return OP_IMM_32;
			default: return OP_REG_32;
		endcase
	endfunction

	function automatic logic [31:0] make_word(input funct7_t f7, input funct3_t f3,
			input opcode_t op);
		logic [31:0] w;
		w = $urandom();
		w[31:25] = f7;
		w[14:12] = f3;
		w[6:0] = op;
		return w;
	endfunction

	function automatic logic [31:0] random_word();
		logic [31:0] w;
		int unsigned pick;
		w = $urandom();
		pick = $urandom_range(0, 99);
		if (pick < 85) begin
			w[6:0] = known_opcode($urandom_range(0, 12));
			case ($urandom_range(0, 3))
				0: w[31:25] = F7_BASE;
				1: w[31:25] = F7_MULDIV;
				2: w[31:25] = F7_ALT;
				default: ;
			endcase
			if (w[6:0] == OP_IMM && $urandom_range(0, 1) == 1)
				w[31:26] = ($urandom_range(0, 1) == 1) ? F6_ALT : F6_BASE;
			if (w[6:0] == OP_SYSTEM && $urandom_range(0, 3) == 0)
				w = ($urandom_range(0, 1) == 1) ? WORD_EBREAK : WORD_ECALL;
		end else if (pick < 92) begin
			w[6:0] = known_opcode($urandom_range(0, 12));
		end
		return w;
	endfunction

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin : driver
		int unsigned gap_left;
		int unsigned burst_left;
		if (!arst_n) begin
			in_valid <= 1'b0;
			instruction <= '0;
			gap_left = 0;
			burst_left = 8;
		end else if (!in_valid || !in_stall) begin
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				in_valid <= 1'b1;
				instruction <= pending_words.pop_front();
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 32);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall pattern in four rotating modes, plus one long hold-off.
	always @(posedge clk or negedge arst_n) begin : receiver
		int unsigned rx_cycle;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_cycle = 0;
		end else begin
			rx_cycle++;
			if (rx_cycle >= HoldStart && rx_cycle < HoldStart + HoldCycles) begin
				out_stall <= 1'b1;
			end else begin
				case ((rx_cycle / 64) % 4)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 9) < 3);
					2: out_stall <= ($urandom_range(0, 9) < 7);
					default: out_stall <= rx_cycle[2];
				endcase
			end
		end
	end

	always @(posedge clk) begin : monitor
		rvic_result_t got;
		rvic_result_t want;
		if (arst_n) begin
			if (in_valid && in_stall)
				input_stall_cycles++;
			if (out_valid && !out_stall) begin
				got.instr_class = instr_class;
				got.unknown_opcode = unknown_opcode;
				checked_count++;
				if (got.instr_class < NumClasses)
					class_seen[got.instr_class] = 1'b1;
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("ERROR: result with no transaction pending: class %0d unknown %0b",
							got.instr_class, got.unknown_opcode);
				end else begin
					want = expected_results.pop_front();
					if (got.instr_class !== want.instr_class ||
							got.unknown_opcode !== want.unknown_opcode) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("ERROR: result %0d: expected class %0d unknown %0b, got class %0d unknown %0b",
								checked_count, want.instr_class, want.unknown_opcode,
								got.instr_class, got.unknown_opcode);
					end
				end
			end
			if (in_valid && !in_stall)
				expected_results.push_back(predict_class(instruction));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$display("ERROR: no transaction for %0d cycles", IdleLimit);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int unsigned seen;
		pending_words.push_back(32'h00000000);
		pending_words.push_back(32'hFFFFFFFF);
		pending_words.push_back(WORD_ECALL);
		pending_words.push_back(WORD_EBREAK);
		pending_words.push_back(32'h00200073);
		pending_words.push_back(WORD_ECALL | 32'h00000080);
		pending_words.push_back(make_word({F6_BASE, 1'b1}, 3'd1, OP_IMM));
		pending_words.push_back(make_word({F6_ALT, 1'b1}, 3'd5, OP_IMM));
		pending_words.push_back(make_word(7'b0000010, 3'd5, OP_IMM));
		pending_words.push_back(make_word(F7_MULDIV, 3'd1, OP_IMM_32));
		pending_words.push_back(make_word(F7_ALT, 3'd5, OP_IMM_32));
		pending_words.push_back(make_word(7'h7F, 3'd0, OP_IMM_32));
		pending_words.push_back(make_word(F7_ALT, 3'd0, OP_REG));
		pending_words.push_back(make_word(F7_ALT, 3'd1, OP_REG));
		pending_words.push_back(make_word(F7_MULDIV, 3'd7, OP_REG));
		pending_words.push_back(make_word(F7_MULDIV, 3'd1, OP_REG_32));
		pending_words.push_back(make_word(F7_MULDIV, 3'd7, OP_REG_32));
		pending_words.push_back(make_word(F7_BASE, 3'd1, OP_MISC_MEM));
		pending_words.push_back(make_word(F7_BASE, 3'd2, OP_MISC_MEM));
		pending_words.push_back(make_word(F7_BASE, 3'd1, OP_JALR));
		pending_words.push_back(make_word(F7_BASE, 3'd2, OP_BRANCH));
		pending_words.push_back(make_word(F7_BASE, 3'd7, OP_LOAD));
		pending_words.push_back(make_word(F7_BASE, 3'd4, OP_STORE));
		pending_words.push_back(32'hFFFFFFEF);
		pending_words.push_back(make_word(F7_BASE, 3'd0, 7'b1111011));
		pending_words.push_back(make_word(F7_BASE, 3'd4, OP_SYSTEM));
		pending_words.push_back(make_word(7'h7F, 3'd7, OP_SYSTEM));
		for (int i = 0; i < RandomWords; i++)
			pending_words.push_back(random_word());

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || in_valid)
			@(negedge clk);
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		seen = 0;
		for (int c = 0; c < NumClasses; c++)
			if (class_seen[c])
				seen++;
		$display("Checked %0d results covering %0d of %0d class codes.",
			checked_count, seen, NumClasses);
		$display("Input side was held off for %0d cycles; %0d mismatches found.",
			input_stall_cycles, mismatch_count);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
